// File: design/pfa_pkg.sv
// Package for the page frame allocator: operation, status and state codes,
// command and response structs, fixed field widths. No dependencies.
package pfa_pkg;

    localparam int ADDR_W      = 32;
    localparam int PCOUNT_W    = 13;
    localparam int CNT_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_BYTES = 4096;

    typedef enum logic [1:0] {
        K_INIT  = 2'd0,
        K_ALLOC = 2'd1,
        K_FREE  = 2'd2,
        K_RSVD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END  = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_INIT,
        S_SCAN,
        S_FILL,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [ADDR_W-1:0]   address;
        logic [PCOUNT_W-1:0] page_count;
    } t_cmd;

    typedef struct packed {
        logic              done;
        t_status           status;
        logic [ADDR_W-1:0] base_result;
    } t_rsp;

endpackage

// File: design/pfa_alu.sv
// Shared 32-bit add/subtract unit for the allocator sequencer.
// Depends on pfa_pkg for the address width.
module pfa_alu (
    input  logic [pfa_pkg::ADDR_W-1:0] i_a,
    input  logic [pfa_pkg::ADDR_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [pfa_pkg::ADDR_W-1:0] o_sum,
    output logic                       o_carry
);
    import pfa_pkg::*;

    logic [ADDR_W-1:0] w_b;

    // Subtract as a + ~b + 1; carry set means no borrow
    assign w_b = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, w_b} + {{ADDR_W{1'b0}}, i_sub};

endmodule

// File: design/pfa_engine.sv
// Sequencer and frame use-count memory of the page frame allocator.
// Depends on pfa_pkg and pfa_alu.
module pfa_engine #(
    parameter int FRAMES    = 4096,
    parameter int USED_MARK = 100
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfa_pkg::t_cmd              i_cmd,
    input  logic [pfa_pkg::ADDR_W-1:0] i_base,
    input  logic [pfa_pkg::ADDR_W-1:0] i_mem_end,
    output logic                       o_busy,
    output pfa_pkg::t_rsp              o_rsp
);
    import pfa_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int HW = ADDR_W - FRAME_SHIFT;

    logic [CNT_W-1:0] mem [FRAMES];
    logic [CNT_W-1:0] r_mem_q;
    logic             mem_we, mem_re;
    logic [IW-1:0]    mem_wa, mem_ra;
    logic [CNT_W-1:0] mem_wd;

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PCOUNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0]   r_off, n_off;
    logic [CW-1:0]       r_nfree, n_nfree;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IW-1:0]       r_chk_idx, n_chk_idx;
    logic [CW-1:0]       r_run, n_run;
    logic [IW-1:0]       r_start, n_start;
    logic [IW-1:0]       r_end, n_end;
    logic [PCOUNT_W-1:0] r_cnt, n_cnt;
    logic                r_bad, n_bad;
    logic                r_ok, n_ok;
    logic                r_clear, n_clear;
    t_rsp                r_rsp, n_rsp;

    logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;

    logic [CW-1:0]     run_next;
    logic [HW-1:0]     frame_hi;
    logic              last_free;
    t_status           fin_status;

    pfa_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    assign run_next  = (r_mem_q == '0) ? r_run + CW'(1) : '0;
    assign frame_hi  = r_off[ADDR_W-1:FRAME_SHIFT];
    assign last_free = ({1'b0, r_cnt} + (PCOUNT_W+1)'(1)) == {1'b0, r_count};

    always_comb begin
        case (r_kind)
            K_ALLOC: fin_status = r_ok ? ST_OK : ST_OOM;
            K_FREE:  fin_status = r_bad ? ST_BAD : ST_OK;
            default: fin_status = ST_OK;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_addr    = r_addr;
        n_count   = r_count;
        n_off     = r_off;
        n_nfree   = r_nfree;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_chk_idx = r_chk_idx;
        n_run     = r_run;
        n_start   = r_start;
        n_end     = r_end;
        n_cnt     = r_cnt;
        n_bad     = r_bad;
        n_ok      = r_ok;
        n_clear   = r_clear;
        n_rsp     = r_rsp;
        n_rsp.done = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;
        alu_a     = r_off;
        alu_b     = ADDR_W'(FRAME_BYTES);
        alu_sub   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_kind  = i_cmd.kind;
                    n_addr  = i_cmd.address;
                    n_count = i_cmd.page_count;
                    n_bad   = 1'b0;
                    n_ok    = 1'b0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                alu_a   = (r_kind == K_INIT) ? i_mem_end : r_addr;
                alu_b   = i_base;
                alu_sub = 1'b1;
                n_off   = alu_sum;
                case (r_kind)
                    K_INIT: begin
                        // Free region only when end lies strictly above base
                        if (alu_carry && alu_sum != '0) begin
                            if (32'(alu_sum[ADDR_W-1:FRAME_SHIFT]) > 32'(FRAMES)) begin
                                n_nfree = CW'(FRAMES);
                            end else begin
                                n_nfree = CW'(alu_sum[ADDR_W-1:FRAME_SHIFT]);
                            end
                        end else begin
                            n_nfree = '0;
                        end
                        n_idx   = '0;
                        n_state = S_INIT;
                    end
                    K_ALLOC: begin
                        if (r_count == '0 || 32'(r_count) > 32'(FRAMES)) begin
                            n_state = S_FINISH;
                        end else begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_run   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    K_FREE: begin
                        n_cnt   = '0;
                        n_state = (r_count == '0) ? S_FINISH : S_FREE_RD;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_idx[IW-1:0];
                mem_wd = (r_idx < r_nfree) ? '0 : CNT_W'(USED_MARK);
                n_idx  = r_idx + CW'(1);
                if (r_idx == CW'(FRAMES - 1)) begin
                    // The clearing pass after reset returns no response
                    n_clear = 1'b0;
                    n_state = r_clear ? S_IDLE : S_FINISH;
                end
            end
            S_SCAN: begin
                // Issue the next read while checking the one returned
                if (r_idx < CW'(FRAMES)) begin
                    mem_re    = 1'b1;
                    mem_ra    = r_idx[IW-1:0];
                    n_pend    = 1'b1;
                    n_chk_idx = r_idx[IW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_run = run_next;
                    if (32'(run_next) == 32'(r_count)) begin
                        n_start = IW'(32'(r_chk_idx) + 32'd1 - 32'(r_count));
                        n_end   = r_chk_idx;
                        n_idx   = CW'(32'(r_chk_idx) + 32'd1 - 32'(r_count));
                        n_ok    = 1'b1;
                        n_state = S_FILL;
                    end else if (r_chk_idx == IW'(FRAMES - 1)) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_idx[IW-1:0];
                mem_wd = CNT_W'(1);
                n_idx  = r_idx + CW'(1);
                if (r_idx[IW-1:0] == r_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FREE_RD: begin
                if (32'(frame_hi) < 32'(FRAMES)) begin
                    mem_re  = 1'b1;
                    mem_ra  = frame_hi[IW-1:0];
                    n_state = S_FREE_WR;
                end else begin
                    // Skip out-of-range frame and flag it
                    n_bad   = 1'b1;
                    n_off   = alu_sum;
                    n_cnt   = r_cnt + PCOUNT_W'(1);
                    n_state = last_free ? S_FINISH : S_FREE_RD;
                end
            end
            S_FREE_WR: begin
                if (r_mem_q != '0) begin
                    mem_we = 1'b1;
                    mem_wa = frame_hi[IW-1:0];
                    mem_wd = r_mem_q - CNT_W'(1);
                end
                n_off   = alu_sum;
                n_cnt   = r_cnt + PCOUNT_W'(1);
                n_state = last_free ? S_FINISH : S_FREE_RD;
            end
            S_FINISH: begin
                alu_a = i_base;
                alu_b = ADDR_W'(r_start) << FRAME_SHIFT;
                n_rsp.done        = 1'b1;
                n_rsp.status      = fin_status;
                n_rsp.base_result = (r_kind == K_ALLOC && r_ok) ? alu_sum : '0;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Start with a clearing pass over the whole map
            r_state    <= S_INIT;
            r_kind     <= K_INIT;
            r_idx      <= '0;
            r_nfree    <= CW'(FRAMES);
            r_clear    <= 1'b1;
            r_pend     <= 1'b0;
            r_bad      <= 1'b0;
            r_ok       <= 1'b0;
            r_rsp.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kind     <= n_kind;
            r_idx      <= n_idx;
            r_nfree    <= n_nfree;
            r_clear    <= n_clear;
            r_pend     <= n_pend;
            r_bad      <= n_bad;
            r_ok       <= n_ok;
            r_rsp      <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr            <= n_addr;
        r_count           <= n_count;
        r_off             <= n_off;
        r_chk_idx         <= n_chk_idx;
        r_run             <= n_run;
        r_start           <= n_start;
        r_end             <= n_end;
        r_cnt             <= n_cnt;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_rsp  = r_rsp;

endmodule

// File: design/page_frame_allocator_core.sv
// Page frame allocator top level: config registers, command and result ports.
// Init writes every entry of the count memory before o_done; alloc runs a
// one-per-cycle first-fit scan of the count memory, then one write per frame;
// free reads each in-range frame, then writes back its decremented count, and skips out-of-range frames.
// After reset the block is busy while it clears the map.
// One command at a time; the next is taken while o_done is high, no stall.
module page_frame_allocator_core #(
    parameter int FRAMES    = 4096,
    parameter int USED_MARK = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_kind,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_address,
    input  logic [pfa_pkg::PCOUNT_W-1:0]  i_page_count,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [pfa_pkg::ADDR_W-1:0]    o_base_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pfa_pkg::*;

    logic [ADDR_W-1:0] r_base, r_mem_end;
    logic              busy;
    t_cmd              cmd;
    t_rsp              rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_mem_end <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Drop writes to indexes beyond the register list
            case (i_cfg_index)
                CFG_BASE: r_base    <= i_cfg_data;
                CFG_END:  r_mem_end <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign cmd.valid      = i_start && !busy;
    assign cmd.kind       = t_kind'(i_kind);
    assign cmd.address    = i_address;
    assign cmd.page_count = i_page_count;

    pfa_engine #(
        .FRAMES    (FRAMES),
        .USED_MARK (USED_MARK)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_base    (r_base),
        .i_mem_end (r_mem_end),
        .o_busy    (busy),
        .o_rsp     (rsp)
    );

    assign o_busy        = busy;
    assign o_done        = rsp.done;
    assign o_status      = rsp.status;
    assign o_base_result = rsp.base_result;

endmodule

// File: bench/tb_page_frame_allocator_core.sv
// Self-checking bench for page_frame_allocator_core: directed and random init, alloc
// and free traffic against a shadow frame use-count map, plus config window changes.
// Depends on pfa_pkg and the RTL only.
module tb_page_frame_allocator_core;
    import pfa_pkg::*;

    localparam int FRAMES        = 4096;
    localparam int USED_MARK     = 100;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 2 * FRAMES + 16;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] base_result;
    } t_frame_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_start      = 1'b0;
    logic [1:0]           i_kind       = K_INIT;
    logic [ADDR_W-1:0]    i_address    = '0;
    logic [PCOUNT_W-1:0]  i_page_count = '0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_BASE;
    logic [ADDR_W-1:0]    i_cfg_data   = '0;
    logic                 o_busy;
    logic                 o_done;
    logic [1:0]           o_status;
    logic [ADDR_W-1:0]    o_base_result;
    logic                 o_cfg_ready;

    // shadow copy of the map and the window registers
    logic [CNT_W-1:0]  shadow_counts [FRAMES];
    logic [ADDR_W-1:0] shadow_base = '0;
    logic [ADDR_W-1:0] shadow_end  = '0;

    t_frame_result     awaited_results[$];
    logic [ADDR_W-1:0] live_run_addr[$];
    int unsigned       live_run_len[$];
    int unsigned       idle_pct    = 0;
    int unsigned       mismatches  = 0;
    int unsigned       cycle_count = 0;

    page_frame_allocator_core #(
        .FRAMES   (FRAMES),
        .USED_MARK(USED_MARK)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_page_count (i_page_count),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_base_result(o_base_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_frame_result predict_frame_op(input t_kind kind,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [PCOUNT_W-1:0] cnt);
        t_frame_result     r;
        int unsigned       nfree;
        int unsigned       run;
        int unsigned       first;
        bit                found;
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W-1:0] frame;
        r.status      = ST_OK;
        r.base_result = '0;
        case (kind)
            K_INIT: begin
                nfree = 0;
                if (shadow_end > shadow_base)
                    nfree = (shadow_end - shadow_base) >> FRAME_SHIFT;
                if (nfree > FRAMES)
                    nfree = FRAMES;
                for (int i = 0; i < FRAMES; i++)
                    shadow_counts[i] = (i < nfree) ? '0 : CNT_W'(USED_MARK);
            end
            K_ALLOC: begin
                found = 1'b0;
                run   = 0;
                if (cnt != 0 && cnt <= FRAMES) begin
                    for (int i = 0; i < FRAMES; i++) begin
                        if (!found) begin
                            run = (shadow_counts[i] == 0) ? run + 1 : 0;
                            if (run == cnt) begin
                                first = i + 1 - cnt;
                                for (int k = first; k <= i; k++)
                                    shadow_counts[k] = CNT_W'(1);
                                r.base_result = shadow_base + first * FRAME_BYTES;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (!found)
                    r.status = ST_OOM;
            end
            K_FREE: begin
                for (int i = 0; i < cnt; i++) begin
                    offs  = addr + ADDR_W'(i) * ADDR_W'(FRAME_BYTES) - shadow_base;
                    frame = offs >> FRAME_SHIFT;
                    if (frame < FRAMES) begin
                        if (shadow_counts[frame] != 0)
                            shadow_counts[frame] = shadow_counts[frame] - 1'b1;
                    end else begin
                        r.status = ST_BAD;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d base_result %h", o_status, o_base_result);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_base_result !== want.base_result) begin
                    $error("base_result expected %h actual %h", want.base_result, o_base_result);
                    mismatches++;
                end
            end
        end
    end

    // Hold start high across back-to-back items; drop it only for a gap.
    task automatic pause_sender();
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic issue_frame_op(input t_kind kind, input logic [ADDR_W-1:0] addr,
                                  input int unsigned cnt);
        t_frame_result       r;
        logic [PCOUNT_W-1:0] pc;
        pc           = PCOUNT_W'(cnt);
        i_start      <= 1'b1;
        i_kind       <= kind;
        i_address    <= addr;
        i_page_count <= pc;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = predict_frame_op(kind, addr, pc);
        awaited_results.push_back(r);
        if (kind == K_INIT) begin
            live_run_addr.delete();
            live_run_len.delete();
        end else if (kind == K_ALLOC && r.status == ST_OK) begin
            live_run_addr.push_back(r.base_result);
            live_run_len.push_back(cnt);
        end
        pause_sender();
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_map_window(input logic [ADDR_W-1:0] base,
                                    input logic [ADDR_W-1:0] limit_addr);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_base = base;
        i_cfg_index <= CFG_END;
        i_cfg_data  <= limit_addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_end = limit_addr;
        i_cfg_valid <= 1'b0;
    endtask

    // map is all free out of reset, window registers are zero
    task automatic test_reset_map();
        issue_frame_op(K_ALLOC, '0, 1);
        issue_frame_op(K_FREE, '0, 1);
    endtask

    task automatic test_small_region();
        logic [ADDR_W-1:0] b;
        b = 32'h8000_0000;
        write_map_window(b, b + 20 * FRAME_BYTES + 123);
        issue_frame_op(K_INIT, '0, 0);
        issue_frame_op(K_ALLOC, '0, 0);
        issue_frame_op(K_ALLOC, '0, 4096);
        issue_frame_op(K_ALLOC, '0, 1);
        issue_frame_op(K_ALLOC, '0, 19);
        issue_frame_op(K_ALLOC, '0, 1);
        issue_frame_op(K_FREE, b + 5 * FRAME_BYTES + 32'hFFF, 3);
        issue_frame_op(K_ALLOC, '0, 3);
        // first frame wraps below the base, the other two are still released
        issue_frame_op(K_FREE, b - FRAME_BYTES, 3);
        issue_frame_op(K_FREE, b, 0);
        issue_frame_op(K_FREE, 32'hFFFF_FFFF, 1);
        issue_frame_op(K_RSVD, 32'hFFFF_FFFF, 4096);
        issue_frame_op(K_FREE, b, 4096);
        issue_frame_op(K_FREE, b + 100 * FRAME_BYTES, 4096);
    endtask

    task automatic test_empty_region();
        write_map_window(32'hFFFF_F000, 32'h0000_0010);
        issue_frame_op(K_INIT, '0, 0);
        issue_frame_op(K_ALLOC, '0, 1);
        issue_frame_op(K_FREE, 32'hFFFF_F000, 1);
    endtask

    task automatic test_full_map();
        write_map_window('0, 32'hFFFF_FFFF);
        issue_frame_op(K_INIT, '0, 0);
        issue_frame_op(K_ALLOC, '0, 4096);
        issue_frame_op(K_ALLOC, '0, 1);
        issue_frame_op(K_FREE, '0, 4096);
        issue_frame_op(K_ALLOC, 32'hFFFF_FFFF, 1);
    endtask

    task automatic test_random_traffic(input int unsigned pct, input int unsigned n_items);
        logic [ADDR_W-1:0] b;
        int unsigned       roll;
        int unsigned       idx;
        int unsigned       len;
        idle_pct = pct;
        b = $urandom_range(0, 32'hF000_0000);
        write_map_window(b, b + $urandom_range(8, 64) * FRAME_BYTES + $urandom_range(0, 4095));
        issue_frame_op(K_INIT, $urandom, $urandom_range(0, 4096));
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(99);
            if (roll >= 45 && roll < 80 && live_run_addr.size() != 0) begin
                idx = $urandom_range(0, live_run_addr.size() - 1);
                len = live_run_len[idx];
                if ($urandom_range(3) == 0)
                    len = $urandom_range(1, len);
                issue_frame_op(K_FREE, live_run_addr[idx] + $urandom_range(0, 4095), len);
                live_run_addr.delete(idx);
                live_run_len.delete(idx);
            end else if (roll >= 80 && roll < 88) begin
                issue_frame_op(K_FREE, $urandom, $urandom_range(0, 8));
            end else if (roll >= 88 && roll < 92) begin
                issue_frame_op(K_ALLOC, $urandom,
                               ($urandom_range(1) != 0) ? 0 : $urandom_range(41, 4096));
            end else if (roll >= 92 && roll < 95) begin
                issue_frame_op(K_RSVD, $urandom, $urandom_range(0, 4096));
            end else if (roll >= 95 && roll < 97) begin
                issue_frame_op(K_INIT, $urandom, $urandom_range(0, 4096));
            end else if (roll >= 97) begin
                drain_results();
            end else begin
                issue_frame_op(K_ALLOC, $urandom,
                               ($urandom_range(4) != 0) ? $urandom_range(1, 6)
                                                        : $urandom_range(7, 40));
            end
        end
    endtask

    initial begin
        // map comes out of reset all free
        foreach (shadow_counts[i])
            shadow_counts[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_map();
        test_small_region();
        test_empty_region();
        test_full_map();
        test_random_traffic(0, 40);
        test_random_traffic(78, 40);
        test_random_traffic(17, 40);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
